// ----- design/gate_motor_controller_fsm_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Gate motor controller assertion macros
// Shared property wrappers. They expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef GATE_MOTOR_CONTROLLER_FSM_UNIT_DEFINES_SVH
`define GATE_MOTOR_CONTROLLER_FSM_UNIT_DEFINES_SVH

// same-cycle implication
`define GMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/gmc_pkg.sv -----
// ----------------------------------------------------------------------------
// Gate motor controller package
// Mode codes, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package gmc_pkg;

  localparam int MODE_W   = 3;
  localparam int SEC_W    = 11;
  localparam int LIMIT_W  = 10;
  localparam int BLINK_W  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [SEC_W-1:0]     sec_t;
  typedef logic [LIMIT_W-1:0]   limit_t;
  typedef logic [BLINK_W-1:0]   blink_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam mode_t MODE_INITIAL = 3'd0;
  localparam mode_t MODE_CLOSING = 3'd1;
  localparam mode_t MODE_OPENING = 3'd2;
  localparam mode_t MODE_CLOSED  = 3'd3;
  localparam mode_t MODE_OPEN    = 3'd4;
  localparam mode_t MODE_ERROR   = 3'd5;
  localparam mode_t MODE_STOP    = 3'd6;

  localparam cfg_idx_t REG_RUN_LIMIT  = 3'd0;
  localparam cfg_idx_t REG_AUTO_CLOSE = 3'd1;
  localparam cfg_idx_t REG_SLOW_BLINK = 3'd2;
  localparam cfg_idx_t REG_FAST_BLINK = 3'd3;
  localparam cfg_idx_t REG_ERROR_BUZZ = 3'd4;

  localparam limit_t RUN_LIMIT_RST  = 10'd180;
  localparam limit_t AUTO_CLOSE_RST = 10'd100;
  localparam blink_t SLOW_BLINK_RST = 6'd2;
  localparam blink_t FAST_BLINK_RST = 6'd1;
  localparam blink_t ERROR_BUZZ_RST = 6'd40;

  localparam sec_t   SECONDS_MAX = 11'd2047;
  localparam blink_t BLINK_MAX   = 6'd63;

endpackage

// ----- design/gate_motor_controller_fsm_unit.sv -----
// Gate opener controller. Takes one input word per clock unless the output stalls and
// returns one registered result word per input word, in the cycle after acceptance; the
// rate is set by the combinational state update feeding the output register. in_tready
// stays high while the output register is empty or being drained. Configuration writes
// are taken at any time when out of reset and should be issued while the block is idle.
// ----------------------------------------------------------------------------
// gate_motor_controller_fsm_unit
// Seven-mode gate controller with travel timeout, auto-close and blink logic.
// ----------------------------------------------------------------------------
module gate_motor_controller_fsm_unit #(
  parameter int TICKS_PER_SECOND = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // in_tdata: [0] limit_closed, [1] limit_open, [2] press_open, [3] press_close,
  //           [4] press_single, [5] press_reset, [6] tick, [7] zero
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [gmc_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [2:0] gate_state, [3] motor_open, [4] motor_close, [5] lamp_on,
  //            [6] buzzer_on, [7] zero
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [gmc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gmc_pkg::*;

  localparam int SubW = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [SubW-1:0] SubLast = SubW'(TICKS_PER_SECOND - 1);

  logic             in_accept;
  logic             cfg_accept;

  limit_t           run_limit_r;
  limit_t           auto_close_r;
  blink_t           slow_blink_r;
  blink_t           fast_blink_r;
  blink_t           error_buzz_r;

  mode_t            mode_r,   mode_nxt;
  sec_t             travel_r, travel_nxt;
  sec_t             open_r,   open_nxt;
  logic [SubW-1:0]  sub_r,    sub_nxt;
  blink_t           blink_r,  blink_nxt;
  logic             lamp_r,   lamp_nxt;
  logic             buzz_r,   buzz_nxt;

  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic lim_closed, lim_open, p_open, p_close, p_single, p_reset, tick;

  assign lim_closed = in_tdata[0];
  assign lim_open   = in_tdata[1];
  assign p_open     = in_tdata[2];
  assign p_close    = in_tdata[3];
  assign p_single   = in_tdata[4];
  assign p_reset    = in_tdata[5];
  assign tick       = in_tdata[6];

  assign in_tready  = rst_n && (!out_valid_r || out_tready);
  assign in_accept  = in_tvalid && in_tready;
  assign cfg_ready  = rst_n;
  assign cfg_accept = cfg_valid && cfg_ready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    mode_t  cur;
    mode_t  tgt;
    logic   change;
    blink_t period;
    blink_t eff;
    logic   hit;

    travel_nxt = travel_r;
    open_nxt   = open_r;
    sub_nxt    = sub_r;
    blink_nxt  = blink_r;
    lamp_nxt   = lamp_r;
    buzz_nxt   = buzz_r;
    cur        = (mode_r > MODE_STOP) ? MODE_INITIAL : mode_r;
    tgt        = cur;
    change     = 1'b0;

    if (tick) begin
      if (blink_r != BLINK_MAX) begin
        blink_nxt = blink_r + 1'b1;
      end
      if (sub_r == SubLast) begin
        sub_nxt = '0;
        if ((cur == MODE_CLOSING || cur == MODE_OPENING) && travel_r != SECONDS_MAX) begin
          travel_nxt = travel_r + 1'b1;
        end
        if (cur == MODE_OPEN && open_r != SECONDS_MAX) begin
          open_nxt = open_r + 1'b1;
        end
      end else begin
        sub_nxt = sub_r + 1'b1;
      end
    end

    // blink / buzz period for the current mode; zero acts as one
    if (cur == MODE_CLOSING) begin
      period = fast_blink_r;
    end else if (cur == MODE_OPENING) begin
      period = slow_blink_r;
    end else begin
      period = error_buzz_r;
    end
    eff = (period == '0) ? BLINK_W'(1) : period;
    hit = (blink_nxt >= eff);

    unique case (cur)
      MODE_INITIAL: begin
        change = 1'b1;
        if (lim_closed && lim_open) begin
          tgt = MODE_ERROR;
        end else if (lim_closed) begin
          tgt = MODE_CLOSED;
        end else if (lim_open) begin
          tgt = MODE_CLOSING;
        end else begin
          tgt = MODE_STOP;
        end
      end
      MODE_CLOSING, MODE_OPENING: begin
        if (hit) begin
          lamp_nxt  = !lamp_r;
          buzz_nxt  = !lamp_r;
          blink_nxt = '0;
        end
        if (cur == MODE_CLOSING && lim_closed) begin
          tgt = MODE_CLOSED;   change = 1'b1;
        end else if (cur == MODE_OPENING && lim_open) begin
          tgt = MODE_OPEN;     change = 1'b1;
        end else if (p_open || p_close || (cur == MODE_OPENING && p_single)) begin
          tgt = MODE_STOP;     change = 1'b1;
        end else if (travel_nxt > {1'b0, run_limit_r}) begin
          tgt = MODE_ERROR;    change = 1'b1;
        end
      end
      MODE_CLOSED: begin
        if (p_open || p_single) begin
          tgt = MODE_OPENING;  change = 1'b1;
        end
      end
      MODE_OPEN: begin
        if (p_close || p_single || (open_nxt >= {1'b0, auto_close_r})) begin
          tgt = MODE_CLOSING;  change = 1'b1;
        end
      end
      MODE_ERROR: begin
        if (hit) begin
          buzz_nxt  = !buzz_r;
          blink_nxt = '0;
        end
        if (p_reset) begin
          tgt = MODE_INITIAL;  change = 1'b1;
        end
      end
      MODE_STOP: begin
        if (p_close && !lim_closed) begin
          tgt = MODE_CLOSING;  change = 1'b1;
        end else if (p_open && !lim_open) begin
          tgt = MODE_OPENING;  change = 1'b1;
        end else if (p_open && p_close) begin
          tgt = MODE_STOP;     change = 1'b1;
        end else if (p_single && !lim_open && !lim_closed) begin
          tgt = MODE_CLOSING;  change = 1'b1;
        end else if (p_reset) begin
          tgt = MODE_INITIAL;  change = 1'b1;
        end
      end
      default: begin
        tgt    = MODE_INITIAL;
        change = 1'b1;
      end
    endcase

    if (change && (tgt == MODE_CLOSING || tgt == MODE_OPENING)) begin
      travel_nxt = '0;
      sub_nxt    = '0;
    end else if (change && tgt == MODE_OPEN) begin
      open_nxt = '0;
      sub_nxt  = '0;
      lamp_nxt = 1'b1;
    end
    mode_nxt = tgt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r  <= RUN_LIMIT_RST;
      auto_close_r <= AUTO_CLOSE_RST;
      slow_blink_r <= SLOW_BLINK_RST;
      fast_blink_r <= FAST_BLINK_RST;
      error_buzz_r <= ERROR_BUZZ_RST;
    end else if (cfg_accept) begin
      case (cfg_index)
        REG_RUN_LIMIT:  run_limit_r  <= cfg_data;
        REG_AUTO_CLOSE: auto_close_r <= cfg_data;
        REG_SLOW_BLINK: slow_blink_r <= cfg_data[BLINK_W-1:0];
        REG_FAST_BLINK: fast_blink_r <= cfg_data[BLINK_W-1:0];
        REG_ERROR_BUZZ: error_buzz_r <= cfg_data[BLINK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_INITIAL;
      travel_r <= '0;
      open_r   <= '0;
      sub_r    <= '0;
      blink_r  <= '0;
      lamp_r   <= 1'b0;
      buzz_r   <= 1'b0;
    end else if (in_accept) begin
      mode_r   <= mode_nxt;
      travel_r <= travel_nxt;
      open_r   <= open_nxt;
      sub_r    <= sub_nxt;
      blink_r  <= blink_nxt;
      lamp_r   <= lamp_nxt;
      buzz_r   <= buzz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= {1'b0, buzz_nxt, lamp_nxt, (mode_nxt == MODE_CLOSING),
                     (mode_nxt == MODE_OPENING), mode_nxt};
    end
  end

endmodule

// ----- design/gmc_checker.sv -----
// ----------------------------------------------------------------------------
// gmc_checker
// Port-level checks for the gate motor controller, bound to the controller module.
// ----------------------------------------------------------------------------
`include "gate_motor_controller_fsm_unit_defines.svh"

module gmc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [gmc_pkg::OUT_DATA_W-1:0] out_tdata
);
  import gmc_pkg::*;

  logic stalled;
  logic opening;
  logic closing;
  logic dir_ok;

  assign stalled = out_tvalid && !out_tready;
  assign opening = (out_tdata[MODE_W-1:0] == MODE_OPENING);
  assign closing = (out_tdata[MODE_W-1:0] == MODE_CLOSING);
  assign dir_ok  = (out_tdata[3] == opening) && (out_tdata[4] == closing);

  `GMC_ASSERT_NEXT(a_out_hold, stalled, out_tvalid && $stable(out_tdata), "stalled word changed")
  `GMC_ASSERT_NEXT(a_one_cycle, in_tvalid && in_tready, out_tvalid, "no word after accept")
  `GMC_ASSERT_NOW(a_ready_empty, !out_tvalid, in_tready, "not ready with empty output")
  `GMC_ASSERT_NOW(a_motor_dir, out_tvalid, dir_ok, "motor drive does not match mode")

endmodule

bind gate_motor_controller_fsm_unit gmc_checker u_gmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gate motor controller testbench
// Sends switch, button and tick words through the input stream and checks
// every result word against a cycle-free model of the controller. Runs a
// directed walk through the mode transitions, then random words shaped
// after the current mode under several register settings, with random
// bursts of idle on both streams.
// ----------------------------------------------------------------------------
module tb;
  import gmc_pkg::*;

  localparam int TICKS_PER_SECOND = 4;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int PHASE_WORDS      = 135;
  localparam int FINAL_PHASE      = 8;
  localparam cfg_idx_t REG_UNUSED_LO = REG_ERROR_BUZZ + 1;
  localparam cfg_idx_t REG_UNUSED_HI = '1;

  // packed from the msb down; limit_closed sits at bit 0
  typedef struct packed {
    logic pad;
    logic tick;
    logic press_reset;
    logic press_single;
    logic press_close;
    logic press_open;
    logic limit_open;
    logic limit_closed;
  } gate_in_t;

  typedef struct packed {
    logic  pad;
    logic  buzzer_on;
    logic  lamp_on;
    logic  motor_close;
    logic  motor_open;
    mode_t gate_state;
  } gate_out_t;

  class gate_checker;
    limit_t      run_limit;
    limit_t      auto_close;
    blink_t      slow_blink;
    blink_t      fast_blink;
    blink_t      error_buzz;
    mode_t       mode;
    sec_t        travel_sec;
    sec_t        open_sec;
    int unsigned subsec;
    blink_t      blink_cnt;
    logic        lamp;
    logic        buzzer;
    gate_out_t   expected_status[$];
    int unsigned fail_count;

    function new();
      run_limit  = RUN_LIMIT_RST;
      auto_close = AUTO_CLOSE_RST;
      slow_blink = SLOW_BLINK_RST;
      fast_blink = FAST_BLINK_RST;
      error_buzz = ERROR_BUZZ_RST;
      mode       = MODE_INITIAL;
      travel_sec = '0;
      open_sec   = '0;
      subsec     = 0;
      blink_cnt  = '0;
      lamp       = 1'b0;
      buzzer     = 1'b0;
      fail_count = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_RUN_LIMIT:  run_limit  = value[LIMIT_W-1:0];
        REG_AUTO_CLOSE: auto_close = value[LIMIT_W-1:0];
        REG_SLOW_BLINK: slow_blink = value[BLINK_W-1:0];
        REG_FAST_BLINK: fast_blink = value[BLINK_W-1:0];
        REG_ERROR_BUZZ: error_buzz = value[BLINK_W-1:0];
        default: ;
      endcase
    endfunction

    // zero period behaves as one tick
    function bit period_hit(blink_t period);
      return blink_cnt >= ((period == '0) ? blink_t'(1) : period);
    endfunction

    function void toggle_lamp(blink_t period);
      if (period_hit(period)) begin
        lamp      = ~lamp;
        buzzer    = lamp;
        blink_cnt = '0;
      end
    endfunction

    function void accept_sample(gate_in_t s);
      mode_t     nxt;
      bit        change;
      gate_out_t want;
      nxt    = mode;
      change = 1'b0;
      if (s.tick) begin
        if (blink_cnt < BLINK_MAX) blink_cnt++;
        subsec++;
        if (subsec >= TICKS_PER_SECOND) begin
          subsec = 0;
          if ((mode == MODE_CLOSING || mode == MODE_OPENING) && travel_sec < SECONDS_MAX)
            travel_sec++;
          if (mode == MODE_OPEN && open_sec < SECONDS_MAX) open_sec++;
        end
      end
      case (mode)
        MODE_INITIAL: begin
          change = 1'b1;
          if (s.limit_closed && s.limit_open) nxt = MODE_ERROR;
          else if (s.limit_closed) nxt = MODE_CLOSED;
          else if (s.limit_open) nxt = MODE_CLOSING;
          else nxt = MODE_STOP;
        end
        MODE_CLOSING: begin
          toggle_lamp(fast_blink);
          change = 1'b1;
          if (s.limit_closed) nxt = MODE_CLOSED;
          else if (s.press_open || s.press_close) nxt = MODE_STOP;
          else if (travel_sec > run_limit) nxt = MODE_ERROR;
          else change = 1'b0;
        end
        MODE_OPENING: begin
          toggle_lamp(slow_blink);
          change = 1'b1;
          if (s.limit_open) nxt = MODE_OPEN;
          else if (s.press_open || s.press_close || s.press_single) nxt = MODE_STOP;
          else if (travel_sec > run_limit) nxt = MODE_ERROR;
          else change = 1'b0;
        end
        MODE_CLOSED: begin
          if (s.press_open || s.press_single) begin
            nxt    = MODE_OPENING;
            change = 1'b1;
          end
        end
        MODE_OPEN: begin
          if (s.press_close || s.press_single || open_sec >= auto_close) begin
            nxt    = MODE_CLOSING;
            change = 1'b1;
          end
        end
        MODE_ERROR: begin
          if (period_hit(error_buzz)) begin
            buzzer    = ~buzzer;
            blink_cnt = '0;
          end
          if (s.press_reset) begin
            nxt    = MODE_INITIAL;
            change = 1'b1;
          end
        end
        default: begin
          change = 1'b1;
          if (s.press_close && !s.limit_closed) nxt = MODE_CLOSING;
          else if (s.press_open && !s.limit_open) nxt = MODE_OPENING;
          else if (s.press_open && s.press_close) nxt = MODE_STOP;
          else if (s.press_single && !s.limit_open && !s.limit_closed) nxt = MODE_CLOSING;
          else if (s.press_reset) nxt = MODE_INITIAL;
          else change = 1'b0;
        end
      endcase
      if (change) begin
        if (nxt == MODE_CLOSING || nxt == MODE_OPENING) begin
          travel_sec = '0;
          subsec     = 0;
        end else if (nxt == MODE_OPEN) begin
          open_sec = '0;
          subsec   = 0;
          lamp     = 1'b1;
        end
        mode = nxt;
      end
      want.pad         = 1'b0;
      want.buzzer_on   = buzzer;
      want.lamp_on     = lamp;
      want.motor_close = (mode == MODE_CLOSING);
      want.motor_open  = (mode == MODE_OPENING);
      want.gate_state  = mode;
      expected_status.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, logic [2:0] got);
      if (got !== 3'(want)) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(gate_out_t got);
      gate_out_t want;
      if (expected_status.size() == 0) begin
        $error("result word %h with nothing expected", got);
        fail_count++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("gate_state", want.gate_state, got.gate_state);
      compare_field("motor_open", want.motor_open, 3'(got.motor_open));
      compare_field("motor_close", want.motor_close, 3'(got.motor_close));
      compare_field("lamp_on", want.lamp_on, 3'(got.lamp_on));
      compare_field("buzzer_on", want.buzzer_on, 3'(got.buzzer_on));
      compare_field("pad", want.pad, 3'(got.pad));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gate_checker tracker = new();
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  gate_motor_controller_fsm_unit #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [0] lc, [1] lo, [2] po, [3] pc, [4] ps, [5] pr, [6] tick
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [2:0] state, [3] m_open, [4] m_close, [5] lamp, [6] buzzer
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic gate_in_t mk(bit lc, bit lo, bit po, bit pc, bit ps, bit pr, bit tk);
    gate_in_t s;
    s = '0;
    s.limit_closed = lc;
    s.limit_open   = lo;
    s.press_open   = po;
    s.press_close  = pc;
    s.press_single = ps;
    s.press_reset  = pr;
    s.tick         = tk;
    return s;
  endfunction

  // switch levels follow the motor most of the time, buttons are rare
  function automatic gate_in_t next_sample(mode_t m);
    gate_in_t s;
    s = '0;
    if ($urandom_range(0, 9) == 0) begin
      s = gate_in_t'(8'($urandom_range(0, 127)));
      return s;
    end
    case (m)
      MODE_CLOSING: begin
        s.limit_closed = ($urandom_range(0, 11) == 0);
        s.limit_open   = ($urandom_range(0, 19) == 0);
      end
      MODE_OPENING: begin
        s.limit_open   = ($urandom_range(0, 11) == 0);
        s.limit_closed = ($urandom_range(0, 19) == 0);
      end
      MODE_CLOSED: s.limit_closed = ($urandom_range(0, 9) != 0);
      MODE_OPEN:   s.limit_open   = ($urandom_range(0, 9) != 0);
      default: begin
        s.limit_closed = ($urandom_range(0, 2) == 0);
        s.limit_open   = ($urandom_range(0, 2) == 0);
      end
    endcase
    s.press_open   = ($urandom_range(0, 13) == 0);
    s.press_close  = ($urandom_range(0, 13) == 0);
    s.press_single = ($urandom_range(0, 13) == 0);
    s.press_reset  = ($urandom_range(0, (m == MODE_ERROR) ? 19 : 29) == 0);
    s.tick         = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  task automatic send_word(gate_in_t w);
    in_tdata  <= w;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.accept_sample(w);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  // upper data bits of the 6-bit registers are junk and must be masked off
  task automatic apply_setting(int unsigned run, int unsigned auto_s, int unsigned slow,
                               int unsigned fast, int unsigned buzz);
    drain();
    write_reg(REG_RUN_LIMIT, CFG_DATA_W'(run));
    write_reg(REG_AUTO_CLOSE, CFG_DATA_W'(auto_s));
    write_reg(REG_SLOW_BLINK, {4'($urandom_range(0, 15)), 6'(slow)});
    write_reg(REG_FAST_BLINK, {4'($urandom_range(0, 15)), 6'(fast)});
    write_reg(REG_ERROR_BUZZ, {4'($urandom_range(0, 15)), 6'(buzz)});
    write_reg(cfg_idx_t'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
              CFG_DATA_W'($urandom_range(0, 1023)));
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_word(next_sample(tracker.mode));
      if (gap_pct != 0 && $urandom_range(0, 199) == 0) drain();
    end
  endtask

  function automatic int unsigned pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct   = 25;
    stall_pct = 25;

    send_word(mk(1, 1, 0, 0, 0, 0, 1));
    send_word(mk(0, 0, 0, 0, 0, 1, 0));
    send_word(mk(1, 0, 0, 0, 0, 0, 1));
    send_word(mk(1, 0, 1, 0, 0, 0, 1));
    send_word(mk(0, 0, 0, 0, 1, 0, 1));
    send_word(mk(0, 0, 0, 0, 0, 1, 0));
    send_word(mk(0, 1, 0, 0, 0, 0, 1));
    send_word(mk(0, 0, 0, 1, 0, 0, 1));
    send_word(mk(0, 0, 0, 0, 1, 0, 1));
    send_word(mk(1, 0, 0, 0, 0, 0, 1));
    send_word(mk(1, 0, 0, 0, 1, 0, 0));
    send_word(mk(0, 1, 0, 0, 0, 0, 1));
    send_word(mk(0, 1, 0, 1, 0, 0, 1));
    send_word(mk(0, 0, 1, 0, 0, 0, 1));
    send_word(mk(1, 1, 1, 1, 0, 0, 1));
    send_word(mk(0, 0, 0, 1, 0, 0, 1));
    send_word(mk(0, 0, 0, 1, 0, 0, 1));
    send_word(mk(0, 0, 1, 0, 0, 0, 1));
    send_word(mk(0, 0, 1, 0, 0, 0, 1));
    send_word(mk(0, 0, 1, 0, 0, 0, 1));
    send_word(mk(0, 1, 0, 0, 0, 0, 1));
    send_word(mk(0, 1, 0, 0, 1, 0, 1));
    send_word(mk(0, 0, 0, 0, 0, 0, 1));
    send_word(mk(0, 0, 1, 0, 0, 0, 1));
    send_word(mk(1, 0, 0, 0, 1, 1, 1));
    send_word(mk(0, 0, 0, 0, 0, 0, 1));
    run_random(PHASE_WORDS);

    for (int p = 1; p <= FINAL_PHASE; p++) begin
      case (p)
        1: apply_setting(0, 0, 1, 1, 1);
        2: apply_setting(1023, 1023, 63, 63, 63);
        3: apply_setting(2, 1, 0, 0, 0);
        4: apply_setting(1, 2, 3, 1, 5);
        default: apply_setting($urandom_range(0, 4), $urandom_range(0, 3),
                               $urandom_range(0, 7), $urandom_range(0, 7),
                               ($urandom_range(0, 5) == 0) ? 63 : $urandom_range(0, 9));
      endcase
      gap_pct   = (p == FINAL_PHASE) ? 0 : pick_idle();
      stall_pct = (p == FINAL_PHASE) ? 0 : pick_idle();
      run_random(PHASE_WORDS);
    end

    drain();
    repeat (8) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.expected_status.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/gmc_pkg.sv
design/gate_motor_controller_fsm_unit.sv
design/gmc_checker.sv
bench/tb.sv
